>>> src/tvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_pkg: shared definitions of the three-voice sine chord synthesizer
// Widths, register indexes, the quarter-wave sine table and output helpers.
// ----------------------------------------------------------------------------
package tvs_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int TABLE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS     = 16;

   localparam int NUM_VOICES    = 3;
   localparam int VOICE_BITS    = 2;
   localparam int STEP_BITS     = 32;
   localparam int OUT_BITS      = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int QUARTER_LEN   = 1 << TABLE_ADDR_BITS;
   localparam int AMP_BITS      = SAMPLE_BITS - 3;
   localparam int POS_BITS      = TABLE_ADDR_BITS + 1;

   // angle of one table cell, pi/2 over the quarter length
   localparam real CELL_ANGLE = 1.5707963267948966 / QUARTER_LEN;

   localparam logic [VOICE_BITS-1:0] FIRST_VOICE = '0;
   localparam logic [VOICE_BITS-1:0] LAST_VOICE  = VOICE_BITS'(NUM_VOICES - 1);

   typedef enum logic [1:0] {
      REG_VOICE0_STEP = 2'd0,
      REG_VOICE1_STEP = 2'd1,
      REG_VOICE2_STEP = 2'd2
   } reg_index_type;

   typedef logic [AMP_BITS:0]  sine_word_type;
   typedef sine_word_type      sine_rom_type [0:QUARTER_LEN];
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [OUT_BITS-1:0]    out_sample_type;

   // 1 / ((2n) * (2n + 1)), the ratio of successive Taylor terms of sin
   function automatic real taylor_recip(input int n);
      case (n)
         1:       return 0.16666666666666666;
         2:       return 0.05;
         3:       return 0.023809523809523808;
         4:       return 0.013888888888888889;
         5:       return 0.0090909090909090909;
         6:       return 0.0064102564102564103;
         7:       return 0.0047619047619047619;
         8:       return 0.0036764705882352941;
         9:       return 0.0029239766081871345;
         10:      return 0.0023809523809523810;
         11:      return 0.0019762845849802372;
         12:      return 0.0016666666666666667;
         default: return 0.0;
      endcase
   endfunction

   // sin(k/Q * pi/2) * 2^AMP_BITS, rounded to nearest, evaluated at elaboration
   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      real x;
      real x2;
      real term;
      real sum;
      for (int k = 0; k <= QUARTER_LEN; k++) begin
         x    = CELL_ANGLE * k;
         x2   = x * x;
         term = x;
         sum  = x;
         for (int n = 1; n <= 12; n++) begin
            term = term * x2 * taylor_recip(n);
            if (n[0] == 1'b1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         rom[k] = sine_word_type'($rtoi(sum * (2.0 ** AMP_BITS) + 0.5));
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_TABLE = build_sine();

   // fit a 32-bit step register to the phase width
   function automatic logic [PHASE_BITS-1:0] step_fit(input logic [STEP_BITS-1:0] step);
      return PHASE_BITS'(step);
   endfunction

   // low bits of the two's complement sum, sign-extended when narrower
   function automatic out_sample_type to_out(input sample_type s);
      return OUT_BITS'(s);
   endfunction

endpackage

>>> src/three_voice_sine_chord_synth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_voice_sine_chord_synth: three-voice direct digital sine synthesizer
// One sample per request: three phase accumulators index a shared quarter-wave
// table and the three half-amplitude sines are summed into a Q2.14 sample.
// ----------------------------------------------------------------------------
//
//   channel   ports                               transfer
//   -------   ---------------------------------   ------------------------------
//   request   req_valid/req_ready, req_restart     one sample tick per transfer
//   response  rsp_valid/rsp_ready, rsp_mixed_sample one sample per request
//   config    psel/penable/pwrite/paddr/pwdata     voice steps at 0x0, 0x4, 0x8
//
// A request issues one slot per voice, all through the single read port
// of the phase memory and the single sine ROM; a new request is taken only
// after the last voice of the previous one has issued.
// Synchronous reset clears phases (by valid bits), steps and all control.
// A stalled response parks in a 2-entry queue; requests are also refused
// while two samples are pending, so the pipeline itself never stalls.
// ----------------------------------------------------------------------------
module three_voice_sine_chord_synth import tvs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_restart,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [OUT_BITS-1:0] rsp_mixed_sample,
   // configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } stage_type;

   // configuration
   logic [STEP_BITS-1:0] step0_ff, step0_in;
   logic [STEP_BITS-1:0] step1_ff, step1_in;
   logic [STEP_BITS-1:0] step2_ff, step2_in;
   reg_index_type        csr_index;
   logic                 csr_write;

   // issue sequencer
   logic                  accept;
   logic                  busy_ff, busy_in;
   logic [VOICE_BITS-1:0] voice_ff, voice_in;
   logic                  restart_ff, restart_in;
   logic                  iss_valid;
   logic [VOICE_BITS-1:0] iss_voice;
   logic                  iss_restart;
   stage_type             iss_ctl;

   // phase memory and read-modify-write stage
   logic [PHASE_BITS-1:0] phase_mem [0:NUM_VOICES-1];
   logic [PHASE_BITS-1:0] phase_rd_ff;
   logic [NUM_VOICES-1:0] phase_vld_ff, phase_vld_in;
   stage_type             s1_ff, s1_in;
   logic [VOICE_BITS-1:0] s1_voice_ff;
   logic                  s1_restart_ff;
   logic [PHASE_BITS-1:0] phase_eff;
   logic [PHASE_BITS-1:0] step_sel;
   logic [PHASE_BITS-1:0] phase_next;

   // accumulate stage
   stage_type  s2_ff, s2_in;
   sample_type sine_value;
   sample_type acc_ff;
   sample_type acc_in;
   logic       push;

   // response queue
   out_sample_type q_data_ff [0:1];
   logic           q_wr_ptr_ff, q_wr_ptr_in;
   logic           q_rd_ptr_ff, q_rd_ptr_in;
   logic [1:0]     q_cnt_ff, q_cnt_in;
   logic [1:0]     pend_ff, pend_in;
   logic           pop;

   // ---------------------------------------------------------------- config
   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      step0_in = step0_ff;
      step1_in = step1_ff;
      step2_in = step2_ff;
      if (csr_write) begin
         case (csr_index)
            REG_VOICE0_STEP: step0_in = pwdata;
            REG_VOICE1_STEP: step1_in = pwdata;
            REG_VOICE2_STEP: step2_in = pwdata;
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_VOICE0_STEP: prdata = step0_ff;
         REG_VOICE1_STEP: prdata = step1_ff;
         REG_VOICE2_STEP: prdata = step2_ff;
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- issue
   // Voice 0 issues in the transfer cycle; voices 1 and 2 follow while busy.
   assign req_ready = !busy_ff && (pend_ff != 2'd2);
   assign accept    = req_valid && req_ready;

   assign iss_valid   = accept || busy_ff;
   assign iss_voice   = busy_ff ? voice_ff : FIRST_VOICE;
   assign iss_restart = busy_ff ? restart_ff : req_restart;
   assign iss_ctl     = '{valid: iss_valid,
                          first: iss_valid && !busy_ff,
                          last:  busy_ff && (voice_ff == LAST_VOICE)};

   always_comb begin
      busy_in    = busy_ff;
      voice_in   = voice_ff;
      restart_in = restart_ff;
      if (accept) begin
         busy_in    = 1'b1;
         voice_in   = FIRST_VOICE + VOICE_BITS'(1);
         restart_in = req_restart;
      end else if (busy_ff) begin
         if (voice_ff == LAST_VOICE) begin
            busy_in = 1'b0;
         end
         voice_in = voice_ff + VOICE_BITS'(1);
      end
   end

   // ---------------------------------------------------------------- phase RMW
   // Each voice entry is read once per request and written back the next
   // cycle; the other voices issue before its next read: no forwarding needed.
   always_ff @(posedge clock) begin
      if (iss_valid) begin
         phase_rd_ff <= phase_mem[iss_voice];
      end
      if (s1_ff.valid) begin
         phase_mem[s1_voice_ff] <= phase_next;
      end
   end

   assign s1_in = iss_ctl;

   // entries never written since reset read as zero
   assign phase_eff = (s1_restart_ff || !phase_vld_ff[s1_voice_ff]) ? '0 : phase_rd_ff;

   always_comb begin
      case (s1_voice_ff)
         REG_VOICE0_STEP: step_sel = step_fit(step0_ff);
         REG_VOICE1_STEP: step_sel = step_fit(step1_ff);
         REG_VOICE2_STEP: step_sel = step_fit(step2_ff);
         default:         step_sel = '0;
      endcase
   end

   assign phase_next = phase_eff + step_sel;

   always_comb begin
      phase_vld_in = phase_vld_ff;
      if (s1_ff.valid) begin
         phase_vld_in[s1_voice_ff] = 1'b1;
      end
   end

   tvs_sine_rom u_sine_rom (
      .clock      (clock),
      .rd_en      (s1_ff.valid),
      .phase      (phase_eff),
      .sine_value (sine_value)
   );

   // ---------------------------------------------------------------- accumulate
   assign s2_in  = s1_ff;
   assign acc_in = (s2_ff.first ? '0 : acc_ff) + sine_value;
   assign push   = s2_ff.valid && s2_ff.last;

   always_ff @(posedge clock) begin
      if (s2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // ---------------------------------------------------------------- response
   assign rsp_valid        = (q_cnt_ff != 2'd0);
   assign rsp_mixed_sample = q_data_ff[q_rd_ptr_ff];
   assign pop              = rsp_valid && rsp_ready;

   always_comb begin
      q_wr_ptr_in = push ? !q_wr_ptr_ff : q_wr_ptr_ff;
      q_rd_ptr_in = pop  ? !q_rd_ptr_ff : q_rd_ptr_ff;
      q_cnt_in    = q_cnt_ff + 2'(push) - 2'(pop);
      pend_in     = pend_ff + 2'(accept) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_data_ff[q_wr_ptr_ff] <= to_out(acc_in);
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step0_ff     <= '0;
         step1_ff     <= '0;
         step2_ff     <= '0;
         busy_ff      <= 1'b0;
         voice_ff     <= FIRST_VOICE;
         restart_ff   <= 1'b0;
         phase_vld_ff <= '0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         q_wr_ptr_ff  <= 1'b0;
         q_rd_ptr_ff  <= 1'b0;
         q_cnt_ff     <= 2'd0;
         pend_ff      <= 2'd0;
      end else begin
         step0_ff     <= step0_in;
         step1_ff     <= step1_in;
         step2_ff     <= step2_in;
         busy_ff      <= busy_in;
         voice_ff     <= voice_in;
         restart_ff   <= restart_in;
         phase_vld_ff <= phase_vld_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         q_wr_ptr_ff  <= q_wr_ptr_in;
         q_rd_ptr_ff  <= q_rd_ptr_in;
         q_cnt_ff     <= q_cnt_in;
         pend_ff      <= pend_in;
      end
   end

   // stage payload follows the issue slot
   always_ff @(posedge clock) begin
      if (iss_valid) begin
         s1_voice_ff   <= iss_voice;
         s1_restart_ff <= iss_restart;
      end
   end

endmodule

>>> src/tvs_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_sine_rom: quarter-wave sine lookup
// Folds a phase into a table position, reads the registered ROM and applies
// the quadrant sign to the registered word in the next cycle.
// ----------------------------------------------------------------------------
module tvs_sine_rom import tvs_pkg::*; (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [PHASE_BITS-1:0] phase,
   output sample_type            sine_value
);

   logic [1:0]                 quad;
   logic [TABLE_ADDR_BITS-1:0] frac_addr;
   logic [POS_BITS-1:0]        pos;
   sine_word_type              rom_ff;
   logic                       neg_ff;
   sample_type                 mag;

   assign quad      = phase[PHASE_BITS-1 -: 2];
   assign frac_addr = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
   // mirror odd quadrants
   assign pos = quad[0] ? (POS_BITS'(QUARTER_LEN) - {1'b0, frac_addr})
                        : {1'b0, frac_addr};

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rom_ff <= SINE_TABLE[pos];
         neg_ff <= quad[1];
      end
   end

   assign mag        = signed'(SAMPLE_BITS'(rom_ff));
   assign sine_value = neg_ff ? -mag : mag;

endmodule

>>> src/tvs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_checker: port-level checks of the sine chord synthesizer
// Tracks outstanding requests; checks hold, pacing, no-invent and zero phase.
// ----------------------------------------------------------------------------
module tvs_checker import tvs_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_restart,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [OUT_BITS-1:0] rsp_mixed_sample
);

   logic [1:0] outst_ff, outst_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign outst_in = outst_ff + 2'(req_xfer) - 2'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= 2'd0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   // hold a stalled sample
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mixed_sample))
      else $error("stalled sample changed or dropped");

   // no new request while voices 1 and 2 still issue after a transfer
   a_pacing: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready ##1 !req_ready)
      else $error("request taken while voices still issuing");

   // no sample without a request behind it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outst_ff != 2'd0)
      else $error("sample without outstanding request");

   // a restart into an empty block samples all phases at zero
   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_restart && outst_ff == 2'd0
      |-> ##5 rsp_valid && rsp_mixed_sample == '0)
      else $error("restart sample not zero");

endmodule

bind three_voice_sine_chord_synth tvs_checker u_tvs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_restart      (req_restart),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_mixed_sample (rsp_mixed_sample)
);

>>> dv/three_voice_sine_chord_synth_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_voice_sine_chord_synth_tb: self-checking bench of the chord synthesizer
// Drives sample ticks, rewrites the three voice steps over the APB port between
// phases, and checks every mixed sample against a bit-exact phase accumulator
// and quarter-wave sine model built from 64-bit fixed point, 60 fraction bits.
// ----------------------------------------------------------------------------
module three_voice_sine_chord_synth_tb;
   import tvs_pkg::*;

   // Cycles of quiet after the last sample before a register write or the end.
   localparam int SETTLE_CYCLES  = 10;
   // Cycles without any transfer before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // First register index past the voice steps; writes to it must be dropped.
   localparam int UNMAPPED_REG   = NUM_VOICES;
   localparam int RANDOM_PHASES  = 8;
   localparam int TICKS_PER_PHASE = 118;
   // pi/2 in 2^-60 units
   localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;
   localparam int FIX_FRAC = 60;

   // ------------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   wire                         req_ready;
   logic                        req_restart = 1'b0;
   wire                         rsp_valid;
   logic                        rsp_ready = 1'b0;
   wire signed [OUT_BITS-1:0]   rsp_mixed_sample;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]    paddr = '0;
   logic [31:0]                 pwdata = '0;
   wire  [31:0]                 prdata;
   wire                         pready;

   three_voice_sine_chord_synth i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mixed_sample (rsp_mixed_sample),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Synthesizer model: sine table, voice steps and phase accumulators
   // ------------------------------------------------------------------------
   sine_word_type               quarter_sine [0:QUARTER_LEN];
   logic [STEP_BITS-1:0]        voice_steps  [NUM_VOICES];
   logic [PHASE_BITS-1:0]       voice_phase  [NUM_VOICES];

   // Stimulus bookkeeping shared by the sequencer, the driver and the monitor
   logic                        pending_ticks [$];
   logic signed [OUT_BITS-1:0]  expected_samples [$];
   logic signed [OUT_BITS-1:0]  oldest_sample;
   int                          ticks_offered = 0;
   int                          tick_transfers = 0;
   int                          send_gap_pct = 0;
   int                          rsp_stall_pct = 0;
   int                          mismatches = 0;
   int                          quiet_cycles = 0;

   // floor(a * b / 2^60)
   function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[FIX_FRAC +: 64];
   endfunction

   // Taylor series of sin(x), 0 <= x <= pi/2, in 2^-60 units
   function automatic logic [63:0] fx_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      x2   = fx_mul(x, x);
      term = x;
      acc  = x;
      for (int n = 1; n <= 12; n++) begin
         term = fx_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      return acc;
   endfunction

   // sin(k/Q * pi/2) scaled to half amplitude, rounded to nearest
   function automatic sine_word_type quarter_sine_entry(input int k);
      logic [63:0] angle;
      logic [63:0] s;
      int          shift;
      angle = fx_mul(HALF_PI_Q60, 64'(k) << (FIX_FRAC - TABLE_ADDR_BITS));
      s     = fx_sine(angle);
      shift = FIX_FRAC - AMP_BITS;
      return sine_word_type'((s + (64'd1 << (shift - 1))) >> shift);
   endfunction

   // Top two phase bits pick the quadrant; the next bits address the table.
   function automatic int phase_to_sine(input logic [PHASE_BITS-1:0] phase);
      logic [1:0]                 quad;
      logic [TABLE_ADDR_BITS-1:0] addr;
      int                         pos;
      int                         mag;
      quad = phase[PHASE_BITS-1 -: 2];
      addr = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
      pos  = quad[0] ? QUARTER_LEN - int'(addr) : int'(addr);
      mag  = int'(quarter_sine[pos]);
      return quad[1] ? -mag : mag;
   endfunction

   // One sample tick: clear on restart, sum the three voices, advance phases.
   function automatic logic signed [OUT_BITS-1:0] mix_tick(input logic restart);
      int total;
      total = 0;
      if (restart) begin
         for (int v = 0; v < NUM_VOICES; v++) begin
            voice_phase[v] = '0;
         end
      end
      for (int v = 0; v < NUM_VOICES; v++) begin
         total          = total + phase_to_sine(voice_phase[v]);
         voice_phase[v] = voice_phase[v] + PHASE_BITS'(voice_steps[v]);
      end
      return OUT_BITS'(total);
   endfunction

   // ------------------------------------------------------------------------
   // Tick driver: present a tick at the falling edge, hold it until transfer
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || tick_transfers == ticks_offered) begin
            if (pending_ticks.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid   <= 1'b1;
               req_restart <= pending_ticks.pop_front();
               ticks_offered++;
            end else begin
               // idle: drop valid and scramble the payload
               req_valid   <= 1'b0;
               req_restart <= 1'($urandom_range(1));
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check samples against the oldest prediction, then predict the
   // sample of any tick transferred at this edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < NUM_VOICES; v++) begin
            voice_phase[v] = '0;
         end
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: sample with no tick outstanding: expected none, actual %0d",
                        $time, rsp_mixed_sample);
               mismatches++;
            end else begin
               oldest_sample = expected_samples.pop_front();
               if (rsp_mixed_sample !== oldest_sample) begin
                  $display("%0t: mixed_sample mismatch: expected %0d, actual %0d",
                           $time, oldest_sample, rsp_mixed_sample);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_samples.push_back(mix_tick(req_restart));
            tick_transfers++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: any transfer or register access resets the quiet count
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer helpers
   // ------------------------------------------------------------------------

   // APB write: setup cycle, then access cycle; the register takes the value
   // at the edge where the access completes.
   task automatic csr_write(input int index, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'(index * 4);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // unmapped indexes leave the steps alone
      if (index < NUM_VOICES) begin
         voice_steps[index] = value;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      pwdata  <= 32'($urandom);
   endtask

   // Hold until every tick is transferred and every sample has come back,
   // then let the pipeline settle.
   task automatic drain;
      while (pending_ticks.size() != 0 || tick_transfers != ticks_offered ||
             expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mix of step shapes: extremes, full random, audio-rate steps, steps on
   // table boundaries and tiny steps that sit in one table cell.
   function automatic logic [31:0] pick_step();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom);
         3: return 32'($urandom_range(200_000_000, 1_000_000));
         4: return 32'($urandom_range(4095)) << (PHASE_BITS - 2 - TABLE_ADDR_BITS);
         default: return 32'($urandom_range(4095));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int gap_pct;
      int stall_pct;

      for (int k = 0; k <= QUARTER_LEN; k++) begin
         quarter_sine[k] = quarter_sine_entry(k);
      end
      for (int v = 0; v < NUM_VOICES; v++) begin
         voice_steps[v] = '0;
         voice_phase[v] = '0;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Steps still at reset: every voice parks at phase zero.
      pending_ticks.push_back(1'b0);
      pending_ticks.push_back(1'b1);
      drain();

      // Quarter-turn steps on all voices: walk the quadrant edges, reaching
      // the full positive and negative range of the sum, then restart mid-way.
      csr_write(int'(REG_VOICE0_STEP), 32'h4000_0000);
      csr_write(int'(REG_VOICE1_STEP), 32'h4000_0000);
      csr_write(int'(REG_VOICE2_STEP), 32'h4000_0000);
      for (int i = 0; i < 8; i++) begin
         pending_ticks.push_back(i == 0 || i == 6);
      end
      drain();

      // Largest and smallest steps, one voice frozen; the write past the
      // last register must leave every step unchanged.
      csr_write(int'(REG_VOICE0_STEP), 32'hFFFF_FFFF);
      csr_write(int'(REG_VOICE1_STEP), 32'h0000_0001);
      csr_write(int'(REG_VOICE2_STEP), 32'h0000_0000);
      csr_write(UNMAPPED_REG, 32'h8000_0000);
      for (int i = 0; i < 6; i++) begin
         pending_ticks.push_back(i == 3);
      end
      drain();

      // Steps one table cell, just short of and just past a quarter turn.
      csr_write(int'(REG_VOICE0_STEP), 32'h0010_0000);
      csr_write(int'(REG_VOICE1_STEP), 32'h3FF0_0000);
      csr_write(int'(REG_VOICE2_STEP), 32'h4010_0000);
      for (int i = 0; i < 6; i++) begin
         pending_ticks.push_back(1'b0);
      end
      drain();

      // Random phases: cycle through the idling modes, new steps each phase.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 61; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 61; end
            default: begin gap_pct = 23; stall_pct = 23; end
         endcase
         csr_write(int'(REG_VOICE0_STEP), pick_step());
         csr_write(int'(REG_VOICE1_STEP), pick_step());
         csr_write(int'(REG_VOICE2_STEP), pick_step());
         if ($urandom_range(3) == 0) begin
            csr_write(UNMAPPED_REG, 32'($urandom));
         end
         send_gap_pct  = gap_pct;
         rsp_stall_pct = stall_pct;
         for (int i = 0; i < TICKS_PER_PHASE; i++) begin
            pending_ticks.push_back($urandom_range(99) < 4);
         end
         drain();
      end

      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> three_voice_sine_chord_synth.f
src/tvs_pkg.sv
src/tvs_sine_rom.sv
src/three_voice_sine_chord_synth.sv
src/tvs_checker.sv
dv/three_voice_sine_chord_synth_tb.sv
